>>> hdl/b64d_pkg.sv
// Shared types, constants and the symbol lookup for the Base64 stream decoder.
package b64d_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_DATA = 2'd0;
  localparam logic [1:0] STATUS_END  = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;
  localparam logic [1:0] STATUS_CAP  = 2'd3;

  // Character constants
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
  localparam logic [7:0] WS_MAX   = 8'd32;   // bytes 1..32 are whitespace

  localparam logic [15:0] LIMIT_RESET = 16'd65533;
  localparam logic [15:0] QUAD_BYTES  = 16'd3;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // Job queue between front and back
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // One queued job: up to three bytes, optionally followed by an end result
  typedef struct packed {
    logic [23:0] bytes;    // first byte in [23:16]
    logic [1:0]  nbytes;
    logic        fin;
    logic [1:0]  status;
  } job_t;

  // Bit 6 set means the character is not an alphabet symbol
  function automatic logic [6:0] b64_symbol(input logic [7:0] c);
    logic [6:0] v;
    v = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

>>> hdl/b64d_char_if.sv
// Input channel carrying one character per transaction.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

>>> hdl/b64d_res_if.sv
// Output channel carrying one decoded result per transaction.
interface b64d_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic [1:0]  status;
  logic        end_of_string;
  logic [15:0] out_count;

  modport source (output valid, output data_byte, output has_byte, output status,
                  output end_of_string, output out_count, input ready);
  modport sink   (input valid, input data_byte, input has_byte, input status,
                  input end_of_string, input out_count, output ready);
endinterface

>>> hdl/b64d_front.sv
// Front end: accepts characters, gathers symbols and queues output jobs.
module b64d_front
  import b64d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  b64d_char_if.sink    in_ch,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         full_i,
  output logic         push_o,
  output job_t         job_o
);

  logic [17:0] acc_q, acc_d, acc_e;
  logic [1:0]  cnt_q, cnt_d, cnt_e;
  logic [15:0] cap_q, cap_d, cap_e;
  logic [15:0] limit_q, limit_d;
  logic        ended_q, ended_d;
  logic        accept;
  logic [7:0]  c;
  logic [6:0]  sym;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign c           = in_ch.char_in;
  assign sym         = b64_symbol(c);

  // State seen by this character: a fresh string after an end
  assign acc_e = ended_q ? '0 : acc_q;
  assign cnt_e = ended_q ? '0 : cnt_q;
  assign cap_e = ended_q ? limit_q : cap_q;

  // Classification and state update
  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    limit_d = limit_q;
    ended_d = ended_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
      cap_d   = cfg_wdata_i;
    end else if (accept) begin
      acc_d   = acc_e;
      cnt_d   = cnt_e;
      cap_d   = cap_e;
      ended_d = 1'b0;
      if (c == CHAR_NUL || c == CHAR_PAD) begin
        // end of string: flush a partial group
        push_o       = 1'b1;
        job_o.fin    = 1'b1;
        job_o.status = STATUS_END;
        case (cnt_e)
          2'd2: begin
            job_o.bytes  = {acc_e[11:4], 16'h0000};
            job_o.nbytes = 2'd1;
          end
          2'd3: begin
            job_o.bytes  = {acc_e[17:10], acc_e[9:2], 8'h00};
            job_o.nbytes = 2'd2;
          end
          default: begin
            job_o.nbytes = 2'd0;
          end
        endcase
        ended_d = 1'b1;
      end else if (sym[6]) begin
        // whitespace is dropped, anything else is an error
        if (c > WS_MAX) begin
          push_o       = 1'b1;
          job_o.fin    = 1'b1;
          job_o.status = STATUS_BAD;
          ended_d      = 1'b1;
        end
      end else if (cnt_e != 2'd3) begin
        acc_d = {acc_e[11:0], sym[5:0]};
        cnt_d = cnt_e + 2'd1;
      end else if (cap_e < QUAD_BYTES) begin
        push_o       = 1'b1;
        job_o.fin    = 1'b1;
        job_o.status = STATUS_CAP;
        ended_d      = 1'b1;
      end else begin
        // full quad: three bytes
        push_o       = 1'b1;
        job_o.bytes  = {acc_e, sym[5:0]};
        job_o.nbytes = 2'd3;
        job_o.status = STATUS_DATA;
        cap_d        = cap_e - QUAD_BYTES;
        acc_d        = '0;
        cnt_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      cnt_q   <= '0;
      cap_q   <= LIMIT_RESET;
      limit_q <= LIMIT_RESET;
      ended_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      limit_q <= limit_d;
      ended_q <= ended_d;
    end
  end

endmodule

>>> hdl/b64d_queue.sv
// Short job queue decoupling the front end from the result generator.
module b64d_queue
  import b64d_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  job_t  job_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  avail_o,
  output job_t  head_o
);

  job_t                mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCOUNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCOUNT_W'(QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCOUNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCOUNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/b64d_back.sv
// Back end: expands queued jobs into results and keeps the byte count.
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  job_t        job_i,
  output logic        pop_o,
  b64d_res_if.source  out_ch
);

  logic [1:0]  idx_q, idx_d;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic        vld_q, vld_d;
  logic [7:0]  byte_q, byte_d;
  logic        has_q, has_d;
  logic [1:0]  stat_q, stat_d;
  logic        eos_q, eos_d;
  logic [15:0] oc_q, oc_d;
  logic        load, is_byte, last;
  logic [7:0]  sel_byte;

  assign load    = !vld_q || out_ch.ready;
  assign is_byte = (idx_q < job_i.nbytes);
  assign last    = is_byte ? ((idx_q + 2'd1 == job_i.nbytes) && !job_i.fin) : 1'b1;
  assign pop_o   = load && avail_i && last;
  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 16'd1;

  // Byte select within the job
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = job_i.bytes[23:16];
      2'd1:    sel_byte = job_i.bytes[15:8];
      default: sel_byte = job_i.bytes[7:0];
    endcase
  end

  // Next result into the output register
  always_comb begin
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    has_d  = has_q;
    stat_d = stat_q;
    eos_d  = eos_q;
    oc_d   = oc_q;
    if (load) begin
      vld_d = avail_i;
      if (avail_i) begin
        idx_d = last ? 2'd0 : idx_q + 2'd1;
        if (is_byte) begin
          byte_d = sel_byte;
          has_d  = 1'b1;
          stat_d = STATUS_DATA;
          eos_d  = 1'b0;
          oc_d   = cnt_inc;
          cnt_d  = cnt_inc;
        end else begin
          byte_d = 8'h00;
          has_d  = 1'b0;
          stat_d = job_i.status;
          eos_d  = 1'b1;
          oc_d   = cnt_q;
          cnt_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    has_q  <= has_d;
    stat_q <= stat_d;
    eos_q  <= eos_d;
    oc_q   <= oc_d;
  end

  assign out_ch.valid         = vld_q;
  assign out_ch.data_byte     = byte_q;
  assign out_ch.has_byte      = has_q;
  assign out_ch.status        = stat_q;
  assign out_ch.end_of_string = eos_q;
  assign out_ch.out_count     = oc_q;

endmodule

>>> hdl/base64_stream_decoder.sv
// Top level of the Base64 stream decoder.
// Takes one character per cycle on in_i while the queue has room. Alphabet symbols
// are gathered in the front end; each fourth symbol, and each '=' or NUL end,
// queues a job of up to three results in a four-entry queue, and the back end hands
// those results out on out_o one per cycle with out_o ready through a registered
// output stage. Whitespace (bytes 1 to 32) and the first three symbols of a quad
// give no result. A quad gives three results for four characters, so a steady
// stream runs at one character per cycle with out_o ready; an end that flushes a
// partial group gives up to three results from one character, and a run of such
// ends stalls input once the queue is full. The end, error and capacity results
// carry end_of_string, and the next character starts a new string. cfg_we_i loads
// the output limit, which also reloads the capacity of the string in progress; write
// it only while the block is idle. Reset needs no clearing pass.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  b64d_char_if.sink    in_i,
  b64d_res_if.source   out_o,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  logic push, pop, full, avail;
  job_t job_in, job_head;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (job_head)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .job_i   (job_head),
    .pop_o   (pop),
    .out_ch  (out_o)
  );

endmodule
